>>> rtl/core/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg: shared types and constants for the Scheme token lexer
// Token word layout, token kinds, lexer modes and result queue sizing.
// ----------------------------------------------------------------------------
package stl_pkg;

  localparam int STL_CW = 8;    // width of one source character
  localparam int STL_KW = 4;    // width of a token kind
  localparam int STL_IW = 63;   // width of an integer value

  localparam logic [STL_IW-1:0] STL_INT_MAX = {STL_IW{1'b1}};

  // Result queue between the lexer front end and the output stage.
  localparam int STL_QDEPTH = 4;
  localparam int STL_QPW    = $clog2(STL_QDEPTH);
  localparam int STL_QCW    = $clog2(STL_QDEPTH + 1);

  // Characters with a meaning of their own.
  localparam logic [STL_CW-1:0] CH_NUL    = 8'h00;
  localparam logic [STL_CW-1:0] CH_TAB    = 8'h09;
  localparam logic [STL_CW-1:0] CH_LF     = 8'h0A;
  localparam logic [STL_CW-1:0] CH_CR     = 8'h0D;
  localparam logic [STL_CW-1:0] CH_SPACE  = 8'h20;
  localparam logic [STL_CW-1:0] CH_DQUOTE = 8'h22;
  localparam logic [STL_CW-1:0] CH_HASH   = 8'h23;
  localparam logic [STL_CW-1:0] CH_SQUOTE = 8'h27;
  localparam logic [STL_CW-1:0] CH_LPAREN = 8'h28;
  localparam logic [STL_CW-1:0] CH_RPAREN = 8'h29;
  localparam logic [STL_CW-1:0] CH_SEMI   = 8'h3B;
  localparam logic [STL_CW-1:0] CH_BSLASH = 8'h5C;

  typedef enum logic [STL_KW-1:0] {
    K_EOF     = 4'd0,
    K_LPAREN  = 4'd1,
    K_RPAREN  = 4'd2,
    K_QUOTE   = 4'd3,
    K_TRUE    = 4'd4,
    K_FALSE   = 4'd5,
    K_STRING  = 4'd6,
    K_SYMBOL  = 4'd7,
    K_INTEGER = 4'd8
  } tok_kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_HASH    = 3'd2,
    MODE_STRING  = 3'd3,
    MODE_ESCAPE  = 3'd4,
    MODE_SYMBOL  = 3'd5,
    MODE_NUMBER  = 3'd6,
    MODE_DRAIN   = 3'd7
  } lex_mode_t;

  // One result word as it travels through the queue.
  typedef struct packed {
    tok_kind_t         kind;
    logic [STL_CW-1:0] text_char;
    logic              text_valid;
    logic [STL_IW-1:0] int_value;
    logic              done;
    logic              err;
  } token_t;

  // Up to two words written into the queue in one cycle.
  typedef struct packed {
    logic [1:0] n;
    token_t     w0;
    token_t     w1;
  } push_t;

  // Queue status seen by the front end and the top level.
  typedef struct packed {
    logic [STL_QCW-1:0] count;
    logic               space_ok;
    logic               head_valid;
  } qstat_t;

endpackage

>>> rtl/core/stl_char_if.sv
// ----------------------------------------------------------------------------
// stl_char_if: source character channel
// Valid/ready channel carrying one source character per word.
// ----------------------------------------------------------------------------
interface stl_char_if;
  logic                       valid;
  logic                       ready;
  logic [stl_pkg::STL_CW-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

>>> rtl/core/stl_token_if.sv
// ----------------------------------------------------------------------------
// stl_token_if: token result channel
// Valid/ready channel carrying one token result per word.
// ----------------------------------------------------------------------------
interface stl_token_if;
  logic                       valid;
  logic                       ready;
  logic [stl_pkg::STL_KW-1:0] token_kind;
  logic [stl_pkg::STL_CW-1:0] text_char;
  logic                       text_valid;
  logic [stl_pkg::STL_IW-1:0] int_value;
  logic                       token_done;
  logic                       error;

  modport source (output valid, output token_kind, output text_char, output text_valid,
                  output int_value, output token_done, output error, input ready);
  modport sink   (input valid, input token_kind, input text_char, input text_valid,
                  input int_value, input token_done, input error, output ready);
endinterface

>>> rtl/core/scheme_token_lexer.sv
// ----------------------------------------------------------------------------
// scheme_token_lexer: streaming Scheme lexer
// One source character per input word, one token result per output word.
// ----------------------------------------------------------------------------
// Usage: characters arrive on the chars channel (valid/ready), one byte per
// word, with a NUL byte marking the end of a text. Results leave on the
// tokens channel, one word per result; a character yields zero, one or two
// results. String and symbol text streams one character per word, and each
// such token ends with a closing word that has token_done set.
// An accepted character's first result passes through the queue and then
// the output register before it is presented. The front end accepts one
// character per cycle whenever the result queue holds room for two words;
// the sustained rate is set by the output stage, which hands out one result
// per cycle while the receiver is ready, so only a run of characters that
// each yield two results slows the input. Input is still taken while the
// receiver stalls until under two of four entries are free, then ready drops.
// Reset (rst, synchronous) returns the lexer to the between-tokens state,
// clears the integer accumulator and empties the queue and output register.
// ----------------------------------------------------------------------------
module scheme_token_lexer (
  input  logic        clk,
  input  logic        rst,
  stl_char_if.sink    chars,
  stl_token_if.source tokens
);
  import stl_pkg::*;

  push_t  push;
  qstat_t qstat;
  token_t head;
  logic   pop;

  // Front end: classifies characters and builds result words.
  stl_front u_front (
    .clk   (clk),
    .rst   (rst),
    .chars (chars),
    .qstat (qstat),
    .push  (push)
  );

  // Queue between the lexer and the output register, so a stalled
  // receiver does not immediately stop the input.
  stl_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  // Output register driving the token channel.
  stl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (qstat.head_valid),
    .pop        (pop),
    .tokens     (tokens)
  );

  // The queue never holds more words than it has entries.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    qstat.count <= STL_QCW'(STL_QDEPTH))
    else $error("result queue overfilled");

  // A lexing error is only ever reported on an end-of-text result.
  a_error_is_eof: assert property (@(posedge clk) disable iff (rst)
    tokens.valid && tokens.error |-> tokens.token_kind == K_EOF)
    else $error("error flag on a non-EOF result");

  // Text characters belong to strings or symbols and never close a token.
  a_text_kind: assert property (@(posedge clk) disable iff (rst)
    tokens.valid && tokens.text_valid |->
      !tokens.token_done &&
      (tokens.token_kind == K_STRING || tokens.token_kind == K_SYMBOL))
    else $error("text character on a wrong result");

endmodule

>>> rtl/core/stl_front.sv
// ----------------------------------------------------------------------------
// stl_front: lexer front end
// Accepts characters, runs the lexer state machine and integer accumulator,
// and pushes zero, one or two result words per character into the queue.
// ----------------------------------------------------------------------------
module stl_front (
  input  logic           clk,
  input  logic           rst,
  stl_char_if.sink       chars,
  input  stl_pkg::qstat_t qstat,
  output stl_pkg::push_t  push
);
  import stl_pkg::*;

  typedef struct packed {
    lex_mode_t mode;
    logic      emit;
    token_t    tok;
    logic      num_start;
  } start_t;

  lex_mode_t         mode, mode_next;
  logic [STL_IW-1:0] accum, accum_next;
  logic [STL_CW-1:0] c;
  logic              fire;
  logic [STL_IW+3:0] acc_sum;
  logic [STL_IW-1:0] acc_sat;
  start_t            st;

  function automatic token_t mk(tok_kind_t k, logic [STL_CW-1:0] ch, logic tv,
                                logic dn, logic er);
    token_t t;
    t.kind       = k;
    t.text_char  = ch;
    t.text_valid = tv;
    t.int_value  = '0;
    t.done       = dn;
    t.err        = er;
    return t;
  endfunction

  function automatic logic is_space(logic [STL_CW-1:0] x);
    return (x == CH_SPACE) || (x >= CH_TAB && x <= CH_CR);
  endfunction

  function automatic logic is_digit(logic [STL_CW-1:0] x);
    return x >= "0" && x <= "9";
  endfunction

  function automatic logic is_initial(logic [STL_CW-1:0] x);
    logic r;
    r = (x >= "a" && x <= "z") || (x >= "A" && x <= "Z");
    case (x)
      "!", "$", "%", "&", "*", "/", ":", "<", "=", ">", "?", "^", "_", "~": r = 1'b1;
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic is_subsequent(logic [STL_CW-1:0] x);
    return is_initial(x) || is_digit(x) || x == "+" || x == "-" || x == "." || x == "@";
  endfunction

  // Classification of a character that starts a new token.
  function automatic start_t start_of(logic [STL_CW-1:0] x);
    start_t s;
    s.mode      = MODE_IDLE;
    s.emit      = 1'b0;
    s.tok       = mk(K_EOF, '0, 1'b0, 1'b1, 1'b0);
    s.num_start = 1'b0;
    if (x == CH_NUL) begin
      s.emit = 1'b1;
    end else if (is_space(x)) begin
      s.emit = 1'b0;
    end else if (x == CH_SEMI) begin
      s.mode = MODE_COMMENT;
    end else if (x == CH_LPAREN) begin
      s.emit = 1'b1;
      s.tok  = mk(K_LPAREN, '0, 1'b0, 1'b1, 1'b0);
    end else if (x == CH_RPAREN) begin
      s.emit = 1'b1;
      s.tok  = mk(K_RPAREN, '0, 1'b0, 1'b1, 1'b0);
    end else if (x == CH_SQUOTE) begin
      s.emit = 1'b1;
      s.tok  = mk(K_QUOTE, '0, 1'b0, 1'b1, 1'b0);
    end else if (x == CH_HASH) begin
      s.mode = MODE_HASH;
    end else if (x == CH_DQUOTE) begin
      s.mode = MODE_STRING;
    end else if (is_initial(x)) begin
      s.emit = 1'b1;
      s.tok  = mk(K_SYMBOL, x, 1'b1, 1'b0, 1'b0);
      s.mode = MODE_SYMBOL;
    end else if (is_digit(x)) begin
      s.mode      = MODE_NUMBER;
      s.num_start = 1'b1;
    end else begin
      // Unsupported character: error end of text, then drain to NUL.
      s.emit = 1'b1;
      s.tok  = mk(K_EOF, '0, 1'b0, 1'b1, 1'b1);
      s.mode = MODE_DRAIN;
    end
    return s;
  endfunction

  assign c           = chars.char_code;
  assign chars.ready = qstat.space_ok;
  assign fire        = chars.valid && qstat.space_ok;
  assign st          = start_of(c);

  // accum * 10 + digit; saturates when the sum passes the largest value.
  assign acc_sum = ({4'b0, accum} << 3) + ({4'b0, accum} << 1) + (STL_IW + 4)'(c - "0");
  assign acc_sat = (acc_sum > {4'b0, STL_INT_MAX}) ? STL_INT_MAX : acc_sum[STL_IW-1:0];

  always_comb begin
    mode_next  = mode;
    accum_next = accum;
    if (fire) begin
      case (mode)
        MODE_IDLE: begin
          mode_next = st.mode;
          if (st.num_start) accum_next = STL_IW'(c - "0");
        end
        MODE_COMMENT: begin
          if (c == CH_NUL || c == CH_LF) mode_next = MODE_IDLE;
        end
        MODE_HASH: begin
          if (c == "t" || c == "T" || c == "f" || c == "F" || c == CH_NUL) begin
            mode_next = MODE_IDLE;
          end else begin
            mode_next = MODE_DRAIN;
          end
        end
        MODE_STRING: begin
          if (c == CH_NUL || c == CH_DQUOTE) mode_next = MODE_IDLE;
          else if (c == CH_BSLASH) mode_next = MODE_ESCAPE;
        end
        MODE_ESCAPE: begin
          mode_next = (c == CH_NUL) ? MODE_IDLE : MODE_STRING;
        end
        MODE_SYMBOL: begin
          if (!is_subsequent(c)) begin
            mode_next = st.mode;
            if (st.num_start) accum_next = STL_IW'(c - "0");
          end
        end
        MODE_NUMBER: begin
          if (is_digit(c)) begin
            accum_next = acc_sat;
          end else begin
            mode_next  = st.mode;
            accum_next = '0;
          end
        end
        MODE_DRAIN: begin
          if (c == CH_NUL) mode_next = MODE_IDLE;
        end
        default: mode_next = MODE_IDLE;
      endcase
    end
  end

  always_comb begin
    push.n  = 2'd0;
    push.w0 = mk(K_EOF, '0, 1'b0, 1'b1, 1'b0);
    push.w1 = st.tok;
    if (fire) begin
      case (mode)
        MODE_IDLE: begin
          push.n  = {1'b0, st.emit};
          push.w0 = st.tok;
        end
        MODE_COMMENT: begin
          if (c == CH_NUL) push.n = 2'd1;
        end
        MODE_HASH: begin
          push.n = 2'd1;
          if (c == "t" || c == "T") push.w0 = mk(K_TRUE, '0, 1'b0, 1'b1, 1'b0);
          else if (c == "f" || c == "F") push.w0 = mk(K_FALSE, '0, 1'b0, 1'b1, 1'b0);
          else push.w0 = mk(K_EOF, '0, 1'b0, 1'b1, 1'b1);
        end
        MODE_STRING: begin
          if (c == CH_NUL) begin
            push.n  = 2'd1;
            push.w0 = mk(K_EOF, '0, 1'b0, 1'b1, 1'b1);
          end else if (c == CH_DQUOTE) begin
            push.n  = 2'd1;
            push.w0 = mk(K_STRING, '0, 1'b0, 1'b1, 1'b0);
          end else if (c != CH_BSLASH) begin
            push.n  = 2'd1;
            push.w0 = mk(K_STRING, c, 1'b1, 1'b0, 1'b0);
          end
        end
        MODE_ESCAPE: begin
          push.n = 2'd1;
          if (c == CH_NUL) push.w0 = mk(K_EOF, '0, 1'b0, 1'b1, 1'b1);
          else if (c == "n") push.w0 = mk(K_STRING, CH_LF, 1'b1, 1'b0, 1'b0);
          else if (c == "t") push.w0 = mk(K_STRING, CH_TAB, 1'b1, 1'b0, 1'b0);
          else if (c == "r") push.w0 = mk(K_STRING, CH_CR, 1'b1, 1'b0, 1'b0);
          else push.w0 = mk(K_STRING, c, 1'b1, 1'b0, 1'b0);
        end
        MODE_SYMBOL: begin
          if (is_subsequent(c)) begin
            push.n  = 2'd1;
            push.w0 = mk(K_SYMBOL, c, 1'b1, 1'b0, 1'b0);
          end else begin
            push.n  = st.emit ? 2'd2 : 2'd1;
            push.w0 = mk(K_SYMBOL, '0, 1'b0, 1'b1, 1'b0);
          end
        end
        MODE_NUMBER: begin
          if (!is_digit(c)) begin
            push.n            = st.emit ? 2'd2 : 2'd1;
            push.w0           = mk(K_INTEGER, '0, 1'b0, 1'b1, 1'b0);
            push.w0.int_value = accum;
          end
        end
        MODE_DRAIN: push.n = 2'd0;
        default:    push.n = 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_IDLE;
      accum <= '0;
    end else begin
      mode  <= mode_next;
      accum <= accum_next;
    end
  end

endmodule

>>> rtl/core/stl_queue.sv
// ----------------------------------------------------------------------------
// stl_queue: result word queue
// Small register queue taking up to two words per cycle and giving one.
// ----------------------------------------------------------------------------
module stl_queue (
  input  logic            clk,
  input  logic            rst,
  input  stl_pkg::push_t  push,
  input  logic            pop,
  output stl_pkg::token_t head,
  output stl_pkg::qstat_t qstat
);
  import stl_pkg::*;

  token_t             slots [STL_QDEPTH];
  logic [STL_QPW-1:0] wr_ptr, wr_ptr_next;
  logic [STL_QPW-1:0] rd_ptr, rd_ptr_next;
  logic [STL_QCW-1:0] count, count_next;
  logic [STL_QPW-1:0] wr_ptr_2nd;

  assign wr_ptr_2nd  = wr_ptr + 1'b1;
  assign wr_ptr_next = wr_ptr + STL_QPW'(push.n);
  assign rd_ptr_next = rd_ptr + STL_QPW'(pop);
  assign count_next  = count + STL_QCW'(push.n) - STL_QCW'(pop);

  assign head             = slots[rd_ptr];
  assign qstat.count      = count;
  assign qstat.head_valid = (count != '0);
  // Room for the two words a single character can produce.
  assign qstat.space_ok   = (count <= STL_QCW'(STL_QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) slots[wr_ptr] <= push.w0;
    if (push.n == 2'd2) slots[wr_ptr_2nd] <= push.w1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

endmodule

>>> rtl/core/stl_back.sv
// ----------------------------------------------------------------------------
// stl_back: token output stage
// Output register that takes words from the queue and drives the channel.
// ----------------------------------------------------------------------------
module stl_back (
  input  logic            clk,
  input  logic            rst,
  input  stl_pkg::token_t head,
  input  logic            head_valid,
  output logic            pop,
  stl_token_if.source     tokens
);
  import stl_pkg::*;

  logic   out_valid;
  token_t out_word;

  assign pop = head_valid && (!out_valid || tokens.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || tokens.ready) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_word <= head;
  end

  assign tokens.valid      = out_valid;
  assign tokens.token_kind = out_word.kind;
  assign tokens.text_char  = out_word.text_char;
  assign tokens.text_valid = out_word.text_valid;
  assign tokens.int_value  = out_word.int_value;
  assign tokens.token_done = out_word.done;
  assign tokens.error      = out_word.err;

endmodule
